// ===== rtl/core/rgbw_pkg.sv =====
// Shared types, register indexes and helpers for the RGB565 replicating writer.
package rgbw_pkg;

	localparam int DIM_W    = 13;
	localparam int POS_W    = 12;
	localparam int SCALE_W  = 4;
	localparam int STRIDE_W = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int WORD_W   = 16;
	localparam int OFFS_W   = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PIXELS_WIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXELS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 2'd3;

	localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       first_of_frame;
	} pixel_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [OFFS_W-1:0] byte_offset;
		logic              last;
	} write_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic h_last;
		logic v_last;
		logic out_free;
	} dp_status_t;

	// Width and height of zero act as one; anything above the limit saturates.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = 13'd1;
		else if (v > DIM_LIMIT)
			r = DIM_LIMIT;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] pack565(input pixel_t p);
		return {p.red[7:3], p.green[7:2], p.blue[7:3]};
	endfunction

endpackage

// ===== rtl/core/rgbw_ctrl.sv =====
// Sequencer that steps each pixel through the multiply cycles and the write burst.
module rgbw_ctrl
	import rgbw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL1 = 2'd1;
	localparam logic [1:0] ST_MUL2 = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign pix_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.h_last && status.v_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/rgbw_dp.sv =====
// Datapath: configuration registers, raster position, offset arithmetic and write register.
module rgbw_dp
	import rgbw_pkg::*;
#(
	parameter int MAX_SCALE = 8,
	parameter int ADDR_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  pixel_t               pix,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	output logic                 wr_valid,
	input  logic                 wr_stall,
	output write_t               wr
);

	localparam logic [32:0] ADDR_MAX = (33'd1 << ADDR_BITS) - 33'd1;
	localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(MAX_SCALE);

	logic [DIM_W-1:0]    wide_q, high_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [STRIDE_W-1:0] stride_q;

	logic [POS_W-1:0]    col_q, row_q;
	logic [POS_W-1:0]    cur_col_q, cur_row_q;
	logic [WORD_W-1:0]   word_q;
	logic [SCALE_W-1:0]  s_q;
	logic [14:0]         rs_q;
	logic [15:0]         cbase_q;
	logic [31:0]         line_q;
	logic [15:0]         colx_q;
	logic [SCALE_W-1:0]  v_q, h_q;
	logic                wr_valid_q;
	write_t              wr_q;

	logic [DIM_W-1:0]    w_eff, h_eff;
	logic [SCALE_W-1:0]  s_eff;
	logic [POS_W-1:0]    col_eff, row_eff;
	logic [DIM_W-1:0]    col_next, row_next;
	logic [15:0]         col_prod;
	logic [32:0]         off_sum;
	logic [32:0]         off_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q   <= 13'd1;
			high_q   <= 13'd1;
			scale_q  <= 4'd1;
			stride_q <= 16'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXELS_WIDE: wide_q   <= cfg_data[DIM_W-1:0];
				REG_PIXELS_HIGH: high_q   <= cfg_data[DIM_W-1:0];
				REG_SCALE:       scale_q  <= cfg_data[SCALE_W-1:0];
				REG_ROW_STRIDE:  stride_q <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_dim(wide_q);
	assign h_eff = clamp_dim(high_q);

	always_comb begin
		if (scale_q == '0)
			s_eff = 4'd1;
		else if (scale_q > SCALE_MAX)
			s_eff = SCALE_MAX;
		else
			s_eff = scale_q;
	end

	// A position left out of bounds by a register change restarts at zero.
	assign col_eff = (pix.first_of_frame || ({1'b0, col_q} >= w_eff)) ? '0 : col_q;
	assign row_eff = (pix.first_of_frame || ({1'b0, row_q} >= h_eff)) ? '0 : row_q;
	assign col_next = {1'b0, col_eff} + 13'd1;
	assign row_next = {1'b0, row_eff} + 13'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (col_next >= w_eff) begin
				col_q <= '0;
				row_q <= (row_next >= h_eff) ? '0 : row_next[POS_W-1:0];
			end else begin
				col_q <= col_next[POS_W-1:0];
				row_q <= row_eff;
			end
		end
	end

	assign col_prod = {4'b0, cur_col_q} * {12'b0, s_q};
	assign off_sum  = {1'b0, line_q} + {17'b0, colx_q};
	assign off_sat  = (off_sum > ADDR_MAX) ? ADDR_MAX : off_sum;

	assign status.h_last   = (h_q == s_q - 4'd1);
	assign status.v_last   = (v_q == s_q - 4'd1);
	assign status.out_free = !wr_valid_q || !wr_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q    <= pack565(pix);
			cur_col_q <= col_eff;
			cur_row_q <= row_eff;
			s_q       <= s_eff;
		end
		if (cmd.mul1) begin
			rs_q    <= 15'({4'b0, cur_row_q} * {12'b0, s_q});
			cbase_q <= {col_prod[14:0], 1'b0};
		end
		if (cmd.mul2) begin
			line_q <= {17'b0, rs_q} * {16'b0, stride_q};
			colx_q <= cbase_q;
			v_q    <= '0;
			h_q    <= '0;
		end
		if (cmd.emit) begin
			wr_q.word        <= word_q;
			wr_q.byte_offset <= off_sat[OFFS_W-1:0];
			wr_q.last        <= status.h_last && status.v_last;
			if (status.h_last) begin
				h_q    <= '0;
				colx_q <= cbase_q;
				if (!status.v_last) begin
					v_q    <= v_q + 4'd1;
					line_q <= line_q + {16'b0, stride_q};
				end
			end else begin
				h_q    <= h_q + 4'd1;
				colx_q <= colx_q + 16'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_valid_q <= 1'b0;
		else if (cmd.emit)
			wr_valid_q <= 1'b1;
		else if (!wr_stall)
			wr_valid_q <= 1'b0;
	end

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

endmodule

// ===== rtl/core/rgb888_to_rgb565_upscale_writer.sv =====
// RGB888 to RGB565 writer with integer pixel replication (top level).
// Each accepted pixel is packed to RGB565 and written scale*scale times, vertical copies
// outer and horizontal copies inner, with the byte offset saturating at 2^ADDR_BITS-1 and
// the final write of the pixel flagged by last. A load step takes each pixel's word,
// then MUL1 (row*scale) and MUL2 (times row_stride) form the row base; writes then
// leave one per cycle through the single output register while the write side does
// not stall. The next pixel is taken while the final write still waits there.
// Write configuration only while the block is idle; the block does not enforce it.
module rgb888_to_rgb565_upscale_writer
	import rgbw_pkg::*;
#(
	parameter int MAX_SCALE = 8,
	parameter int ADDR_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pixel_t               pix,
	output logic                 wr_valid,
	input  logic                 wr_stall,
	output write_t               wr
);

	dp_cmd_t    cmd;
	dp_status_t status;

	rgbw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rgbw_dp #(
		.MAX_SCALE(MAX_SCALE),
		.ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix),
		.cmd      (cmd),
		.status   (status),
		.wr_valid (wr_valid),
		.wr_stall (wr_stall),
		.wr       (wr)
	);

endmodule

// ===== rtl/core/rgbw_checker.sv =====
// Port-level checks for the RGB565 replicating writer, bound to the top level.
module rgbw_checker
	import rgbw_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   pix_valid,
	input logic   pix_stall,
	input logic   wr_valid,
	input logic   wr_stall,
	input write_t wr
);

	// A stalled write word holds until it is taken.
	a_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_stall |=> wr_valid && $stable(wr))
		else $error("write word changed while stalled");

	// Once a pixel is taken, the block is busy in the next cycle.
	a_busy_after_pix: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("pixel side open right after a pixel was taken");

	// While writes of a pixel remain, no new pixel may be taken.
	a_no_pix_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && !wr_stall && !wr.last |-> pix_stall)
		else $error("pixel side open in the middle of a write burst");

	// A write still waiting when a pixel is taken must be the final one of its burst.
	a_wait_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && wr_valid |-> wr.last)
		else $error("pixel taken while a burst was unfinished");

endmodule

bind rgb888_to_rgb565_upscale_writer rgbw_checker u_rgbw_checker (.*);

// ===== sim/tb_rgb888_to_rgb565_upscale_writer.sv =====
// Testbench for the RGB888 to RGB565 writer with integer pixel replication.
`timescale 1ns / 100ps

module tb_rgb888_to_rgb565_upscale_writer;
	import rgbw_pkg::*;

	localparam int                RANDOM_PIXELS = 310;
	localparam int                IDLE_LIMIT    = 5000;
	localparam longint unsigned   OFFSET_MAX    = (64'd1 << 24) - 1;

	// Keeps the expected writes in order and a private copy of position and registers.
	class replica_scoreboard;
		write_t      pending[$];
		int unsigned errors;
		int unsigned wide_reg, high_reg, scale_reg, stride_reg;
		int unsigned col_pos, row_pos;

		function new();
			errors = 0;
			wide_reg = 1;
			high_reg = 1;
			scale_reg = 1;
			stride_reg = 2;
			col_pos = 0;
			row_pos = 0;
		endfunction

		function int unsigned dim_bound(input int unsigned v);
			if (v == 0)
				return 1;
			return (v > 4096) ? 4096 : v;
		endfunction

		function int unsigned scale_factor();
			if (scale_reg == 0)
				return 1;
			return (scale_reg > 8) ? 8 : scale_reg;
		endfunction

		function int unsigned frame_len();
			return dim_bound(wide_reg) * dim_bound(high_reg);
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
			case (idx)
				REG_PIXELS_WIDE: wide_reg = data[DIM_W-1:0];
				REG_PIXELS_HIGH: high_reg = data[DIM_W-1:0];
				REG_SCALE: scale_reg = data[SCALE_W-1:0];
				REG_ROW_STRIDE: stride_reg = data[STRIDE_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out all scale*scale writes of one accepted pixel.
		function void place_pixel(input pixel_t p);
			int unsigned     w, hg, s;
			longint unsigned line, off;
			write_t          exp_wr;
			w = dim_bound(wide_reg);
			hg = dim_bound(high_reg);
			s = scale_factor();
			if (p.first_of_frame) begin
				col_pos = 0;
				row_pos = 0;
			end
			// A register change can leave the position outside the new bounds.
			if (col_pos >= w)
				col_pos = 0;
			if (row_pos >= hg)
				row_pos = 0;
			for (int unsigned v = 0; v < s; v++) begin
				line = (longint'(row_pos) * s + v) * stride_reg;
				for (int unsigned h = 0; h < s; h++) begin
					off = line + (longint'(col_pos) * s + h) * 2;
					exp_wr.word = {p.red[7:3], p.green[7:2], p.blue[7:3]};
					exp_wr.byte_offset = (off > OFFSET_MAX) ? OFFSET_MAX[OFFS_W-1:0] :
						off[OFFS_W-1:0];
					exp_wr.last = (v + 1 == s) && (h + 1 == s);
					pending.push_back(exp_wr);
				end
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= hg)
					row_pos = 0;
			end
		endfunction

		function void check_write(input write_t got);
			write_t exp_wr;
			if (pending.size() == 0) begin
				$display("%0t: unexpected write, expected none, got word %h offset %h last %b",
					$time, got.word, got.byte_offset, got.last);
				errors++;
				return;
			end
			exp_wr = pending.pop_front();
			if (got.word !== exp_wr.word) begin
				$display("%0t: word mismatch, expected %h, got %h", $time, exp_wr.word, got.word);
				errors++;
			end
			if (got.byte_offset !== exp_wr.byte_offset) begin
				$display("%0t: byte_offset mismatch, expected %h, got %h",
					$time, exp_wr.byte_offset, got.byte_offset);
				errors++;
			end
			if (got.last !== exp_wr.last) begin
				$display("%0t: last mismatch, expected %b, got %b", $time, exp_wr.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 pix_valid = 1'b0;
	logic                 pix_stall;
	pixel_t               pix = '0;
	logic                 wr_valid;
	logic                 wr_stall = 1'b0;
	write_t               wr;

	replica_scoreboard sb = new();
	bit                calm = 1'b0;
	int                idle_cycles = 0;
	int                stall_left = 0;
	int                run_left = 0;

	rgb888_to_rgb565_upscale_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.wr_valid (wr_valid),
		.wr_stall (wr_stall),
		.wr       (wr)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly no gap, some short ones and now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic pixel_t mk_pixel(input logic [7:0] r, g, b, input logic f);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.first_of_frame = f;
		return p;
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			wr_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			wr_stall <= 1'b0;
			if (run_left > 0) begin
				run_left <= run_left - 1;
			end else begin
				stall_left <= pick_gap();
				run_left <= $urandom_range(0, 6);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			sb.place_pixel(pix);
		if (arst_n && wr_valid && !wr_stall)
			sb.check_write(wr);
	end

	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (wr_valid && !wr_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("rgb888_to_rgb565_upscale_writer test failed");
			$finish;
		end
	end

	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do
			@(posedge clk);
		while (pix_stall);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_regs(input logic [CFG_W-1:0] w, h, s, st);
		put_reg(REG_PIXELS_WIDE, w);
		put_reg(REG_PIXELS_HIGH, h);
		put_reg(REG_SCALE, s);
		put_reg(REG_ROW_STRIDE, st);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int          sent;
		int          kind;
		int          n;
		int unsigned frame;
		logic [CFG_W-1:0] w, h, s, st;
		logic        f;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values.
		send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1'b1));
		drain();

		// Small frame at scale two: bit cuts, row and frame wrap, restart mid-row.
		write_regs(16'd3, 16'd2, 16'd2, 16'd16);
		send_pixel(mk_pixel(8'hF8, 8'hFC, 8'hF8, 1'b1));
		send_pixel(mk_pixel(8'h07, 8'h03, 8'h07, 1'b0));
		send_pixel(mk_pixel(8'h80, 8'h40, 8'h10, 1'b0));
		send_pixel(mk_pixel(8'h08, 8'h04, 8'h08, 1'b0));
		send_pixel(mk_pixel(8'hAA, 8'h55, 8'hA5, 1'b0));
		send_pixel(mk_pixel(8'h5A, 8'hA5, 8'h5A, 1'b0));
		send_pixel(mk_pixel(8'h12, 8'h34, 8'h56, 1'b0));
		send_pixel(mk_pixel(8'hC3, 8'h3C, 8'h99, 1'b1));
		drain();

		// Zero scale, size and stride.
		write_regs(16'd0, 16'd0, 16'd0, 16'd0);
		send_pixel(mk_pixel(8'h11, 8'h22, 8'h33, 1'b0));
		send_pixel(mk_pixel(8'hEE, 8'hDD, 8'hCC, 1'b0));
		drain();

		// Oversized width, height and scale with a stride of one byte.
		write_regs(16'hFFFF, 16'h1001, 16'h00FF, 16'd1);
		send_pixel(mk_pixel(8'h9C, 8'h63, 8'hF0, 1'b1));
		send_pixel(mk_pixel(8'h0F, 8'hF0, 8'h3C, 1'b0));
		drain();

		// Shrinking the width leaves the column beyond the new bound.
		write_regs(16'd8, 16'd4, 16'd1, 16'd20);
		repeat (5) send_pixel(mk_pixel($urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), 1'b0));
		drain();
		write_regs(16'd3, 16'd4, 16'd1, 16'd20);
		send_pixel(mk_pixel(8'h44, 8'h88, 8'hCC, 1'b0));
		send_pixel(mk_pixel(8'hBB, 8'h77, 8'h33, 1'b0));
		drain();

		sent = 0;
		kind = 0;
		while (sent < RANDOM_PIXELS) begin
			calm = ($urandom_range(0, 3) == 0);
			case (kind)
				0: begin
					// Tall narrow frame at the largest scale walks the offset into saturation.
					w = 16'd1;
					h = $urandom_range(64, 4096);
					s = 16'd8;
					st = $urandom_range(60000, 65535);
					n = 36;
				end
				1: begin
					case ($urandom_range(0, 5))
						0: w = 16'd0;
						1: w = 16'd1;
						2: w = 16'd4096;
						3: w = 16'd4097;
						4: w = 16'h1FFF;
						default: w = $urandom_range(1, 4096);
					endcase
					case ($urandom_range(0, 5))
						0: h = 16'd0;
						1: h = 16'd1;
						2: h = 16'd4096;
						3: h = 16'd4097;
						4: h = 16'h1FFF;
						default: h = $urandom_range(1, 4096);
					endcase
					// Bits above each register's width must be ignored.
					w[15:13] = $urandom_range(0, 7);
					h[15:13] = $urandom_range(0, 7);
					s = $urandom_range(0, 65535);
					case ($urandom_range(0, 4))
						0: st = 16'd0;
						1: st = 16'd1;
						2: st = 16'd2;
						3: st = 16'hFFFF;
						default: st = $urandom_range(0, 65535);
					endcase
					n = $urandom_range(1, 6);
				end
				default: begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 6);
					s = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
					if ($urandom_range(0, 1))
						st = w * s * 2 + $urandom_range(0, 64);
					else
						st = $urandom_range(2, 65535);
					n = $urandom_range(8, 30);
				end
			endcase
			write_regs(w, h, s, st);
			frame = sb.frame_len();
			for (int i = 0; i < n; i++) begin
				if (i % frame == 0)
					f = ($urandom_range(0, 4) != 0);
				else
					f = (kind != 0) && ($urandom_range(0, 19) == 0);
				send_pixel(mk_pixel($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), f));
				sent++;
			end
			drain();
			kind = $urandom_range(0, 9);
		end

		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("rgb888_to_rgb565_upscale_writer test passed");
		else
			$display("rgb888_to_rgb565_upscale_writer test failed");
		$finish;
	end

endmodule
